FILE: design/line_segment_billboard_expander_macros.svh
// Assertion macros shared by the checker of the line billboard expander.
`ifndef LINE_SEGMENT_BILLBOARD_EXPANDER_MACROS_SVH
`define LINE_SEGMENT_BILLBOARD_EXPANDER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define LSBE_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line billboard check failed");

// Consequent must hold in the same cycle as the antecedent.
`define LSBE_ASSERT_NOW(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line billboard check failed");

// Consequent must hold in the cycle after reset is seen.
`define LSBE_ASSERT_AFTER_RESET(name, clk, rst, cons) \
   name: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("line billboard reset check failed");

`endif

FILE: design/lsbe_pkg.sv
`default_nettype none
package lsbe_pkg;

   // square of 0.001 in the Q.33 cross product scale: floor(2^66 / 10^6)
   localparam logic [63:0] LEN_THRESH_SQ = 64'd73786976294838;
   localparam logic [16:0] ALPHA_ONE     = 17'd65536;
   localparam logic [2:0]  LAST_VERTEX   = 3'd5;

   typedef enum logic [2:0] {
      CSR_CAMERA_X   = 3'd0,
      CSR_CAMERA_Y   = 3'd1,
      CSR_CAMERA_Z   = 3'd2,
      CSR_CORE_RED   = 3'd3,
      CSR_CORE_GREEN = 3'd4,
      CSR_CORE_BLUE  = 3'd5,
      CSR_CORE_ALPHA = 3'd6
   } lsbe_csr_type;

   // segment geometry carried alongside the arithmetic
   typedef struct packed {
      logic [2:0][31:0] start_pt;
      logic [2:0][31:0] end_pt;
      logic [30:0]      seg_width;
      logic [16:0]      alpha;
   } lsbe_seg_type;

   // front end to back end: scaled cross product and its squared length
   typedef struct packed {
      lsbe_seg_type     seg;
      logic [2:0][31:0] c2;
      logic [63:0]      sum_sq;
      logic             norm;
   } lsbe_job_type;

   // back end to vertex emitter: half-width offsets per axis
   typedef struct packed {
      lsbe_seg_type     seg;
      logic [2:0][33:0] off;
   } lsbe_quad_type;

   // corner of the quad per vertex: bit 0 = plus side (u), bit 1 = end point (v)
   function automatic logic [1:0] corner_of(input logic [2:0] idx);
      unique case (idx)
         3'd0:    corner_of = 2'd0;
         3'd1:    corner_of = 2'd1;
         3'd2:    corner_of = 2'd2;
         3'd3:    corner_of = 2'd1;
         3'd4:    corner_of = 2'd3;
         3'd5:    corner_of = 2'd2;
         default: corner_of = 2'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

FILE: design/line_segment_billboard_expander.sv
// Path: 8 front stages, a queue, then the back end (idle, multiply, hold when the width
//   vector is used as is; idle, square root, divide, multiply, hold when normalised), then the six-vertex emitter.
// The back end takes no new segment until its quad is taken, so throughput is set by
//   the bit-serial square root (32 steps) and dividers (33 steps) in the back end.
// Reset (synchronous, active high) empties pipeline, queue and emitter and loads the
//   camera (0, 10.0, -10.0) and white core colour; no clearing pass is needed.
`default_nettype none
module line_segment_billboard_expander #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // segment transactions
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_start_x,
   input  logic [31:0] req_start_y,
   input  logic [31:0] req_start_z,
   input  logic [31:0] req_end_x,
   input  logic [31:0] req_end_y,
   input  logic [31:0] req_end_z,
   input  logic [30:0] req_seg_width,
   input  logic [16:0] req_fade,
   // vertex transactions, six per segment
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_vertex_x,
   output logic [31:0] rsp_vertex_y,
   output logic [31:0] rsp_vertex_z,
   output logic [16:0] rsp_out_red,
   output logic [16:0] rsp_out_green,
   output logic [16:0] rsp_out_blue,
   output logic [16:0] rsp_out_alpha,
   output logic        rsp_tex_u,
   output logic        rsp_tex_v,
   output logic        rsp_last_vertex,
   // register writes
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   // configuration registers
   logic [31:0] camera_x_ff, camera_y_ff, camera_z_ff;
   logic [16:0] core_red_ff, core_green_ff, core_blue_ff, core_alpha_ff;

   // front end -> queue -> back end -> emitter
   logic                   job_valid, job_ready;
   lsbe_pkg::lsbe_job_type  job;
   logic                   qjob_valid, qjob_ready;
   lsbe_pkg::lsbe_job_type  qjob;
   logic                   quad_valid, quad_ready;
   lsbe_pkg::lsbe_quad_type quad;

   // writes to an unknown index fall through and are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         camera_x_ff   <= 32'd0;
         camera_y_ff   <= 32'd655360;
         camera_z_ff   <= -32'sd655360;
         core_red_ff   <= lsbe_pkg::ALPHA_ONE;
         core_green_ff <= lsbe_pkg::ALPHA_ONE;
         core_blue_ff  <= lsbe_pkg::ALPHA_ONE;
         core_alpha_ff <= lsbe_pkg::ALPHA_ONE;
      end else if (csr_write_en) begin
         unique case (csr_index)
            lsbe_pkg::CSR_CAMERA_X:   camera_x_ff   <= csr_wdata;
            lsbe_pkg::CSR_CAMERA_Y:   camera_y_ff   <= csr_wdata;
            lsbe_pkg::CSR_CAMERA_Z:   camera_z_ff   <= csr_wdata;
            lsbe_pkg::CSR_CORE_RED:   core_red_ff   <= csr_wdata[16:0];
            lsbe_pkg::CSR_CORE_GREEN: core_green_ff <= csr_wdata[16:0];
            lsbe_pkg::CSR_CORE_BLUE:  core_blue_ff  <= csr_wdata[16:0];
            lsbe_pkg::CSR_CORE_ALPHA: core_alpha_ff <= csr_wdata[16:0];
            default: ;
         endcase
      end
   end

   // front: differences, block scaling, cross product, squared length, alpha fade
   lsbe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .camera     ({camera_z_ff, camera_y_ff, camera_x_ff}),
      .core_alpha (core_alpha_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .in_start   ({req_start_z, req_start_y, req_start_x}),
      .in_end     ({req_end_z, req_end_y, req_end_x}),
      .in_width   (req_seg_width),
      .in_fade    (req_fade),
      .job_valid  (job_valid),
      .job_ready  (job_ready),
      .job        (job)
   );

   // short queue so the front keeps taking transactions while the back iterates
   lsbe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (job_valid),
      .push_ready (job_ready),
      .push_data  (job),
      .pop_valid  (qjob_valid),
      .pop_ready  (qjob_ready),
      .pop_data   (qjob)
   );

   // back: square root and normalising divide when normalised, then half-width offsets
   lsbe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (qjob_valid),
      .job_ready  (qjob_ready),
      .job        (qjob),
      .quad_valid (quad_valid),
      .quad_ready (quad_ready),
      .quad       (quad)
   );

   // emitter holds one quad and plays out its six vertices
   lsbe_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .quad_valid      (quad_valid),
      .quad_ready      (quad_ready),
      .quad            (quad),
      .core_red        (core_red_ff),
      .core_green      (core_green_ff),
      .core_blue       (core_blue_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_vertex_x    (rsp_vertex_x),
      .rsp_vertex_y    (rsp_vertex_y),
      .rsp_vertex_z    (rsp_vertex_z),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_out_alpha   (rsp_out_alpha),
      .rsp_tex_u       (rsp_tex_u),
      .rsp_tex_v       (rsp_tex_v),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule
`default_nettype wire

FILE: design/lsbe_front.sv
`default_nettype none
module lsbe_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [2:0][31:0]      camera,
   input  logic [16:0]           core_alpha,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [2:0][31:0]      in_start,
   input  logic [2:0][31:0]      in_end,
   input  logic [30:0]           in_width,
   input  logic [16:0]           in_fade,
   output logic                  job_valid,
   input  logic                  job_ready,
   output lsbe_pkg::lsbe_job_type job
);

   logic                 adv;
   logic [7:0]           vld_ff, vld_in;

   lsbe_pkg::lsbe_seg_type seg1_ff, seg2_ff, seg3_ff, seg4_ff;
   lsbe_pkg::lsbe_seg_type seg5_ff, seg6_ff, seg7_ff, seg8_ff;
   lsbe_pkg::lsbe_seg_type seg1_in, seg3_in;
   logic [16:0]          fade1_ff;

   // stage 2: direction and doubled camera vector
   logic signed [33:0]   d_in [3];
   logic signed [33:0]   t_in [3];
   logic [33:0]          d2_ff [3];
   logic [33:0]          t2_ff [3];
   logic [33:0]          aprod_in, aprod2_ff;

   // stage 3: block scaled operands
   logic [3:0]           fit_k;
   logic [2:0]           k_in;
   logic signed [33:0]   a_sh [3];
   logic signed [33:0]   b_sh [3];
   logic signed [30:0]   a_in [3];
   logic signed [30:0]   b_in [3];
   logic signed [30:0]   a3_ff [3];
   logic signed [30:0]   b3_ff [3];
   logic                 knz3_ff, knz4_ff, knz5_ff;
   logic [34:0]          rnd;
   logic [18:0]          alpha_q;

   // stage 4/5: cross product
   logic signed [61:0]   m_in [6];
   logic signed [61:0]   m4_ff [6];
   logic signed [62:0]   c_in [3];
   logic signed [62:0]   c5_ff [3];

   // stage 6: second scaling into 32 bits
   logic [31:0]          fit_r;
   logic [5:0]           r_in;
   logic signed [62:0]   c_sh [3];
   logic [2:0][31:0]     c2_in;
   logic [2:0][31:0]     c2_6_ff, c2_7_ff, c2_8_ff;
   logic                 scale6_ff, scale7_ff, scale8_ff;

   // stage 7/8: squared length
   logic [63:0]          sq_in [3];
   logic [63:0]          sq7_ff [3];
   logic [63:0]          sum_in, sum8_ff;

   assign adv       = !vld_ff[7] || job_ready;
   assign req_ready = adv;
   assign vld_in    = {vld_ff[6:0], req_valid};

   always_comb begin
      seg1_in.start_pt  = in_start;
      seg1_in.end_pt    = in_end;
      seg1_in.seg_width = in_width;
      seg1_in.alpha     = '0;

      for (int i = 0; i < 3; i++) begin
         d_in[i] = 34'($signed(seg1_ff.end_pt[i])) - 34'($signed(seg1_ff.start_pt[i]));
         t_in[i] = 34'($signed({camera[i], 1'b0})) - 34'($signed(seg1_ff.start_pt[i]))
                   - 34'($signed(seg1_ff.end_pt[i]));
      end
      aprod_in = core_alpha * fade1_ff;

      // smallest k with every component >> k inside [-2^30, 2^30)
      for (int j = 0; j < 4; j++) begin
         fit_k[j] = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if (((d2_ff[i] ^ {34{d2_ff[i][33]}}) >> (30 + j)) != 34'd0) fit_k[j] = 1'b0;
            if (((t2_ff[i] ^ {34{t2_ff[i][33]}}) >> (30 + j)) != 34'd0) fit_k[j] = 1'b0;
         end
      end
      if (fit_k[0])      k_in = 3'd0;
      else if (fit_k[1]) k_in = 3'd1;
      else if (fit_k[2]) k_in = 3'd2;
      else if (fit_k[3]) k_in = 3'd3;
      else               k_in = 3'd4;
      for (int i = 0; i < 3; i++) begin
         a_sh[i] = $signed(d2_ff[i]) >>> k_in;
         b_sh[i] = $signed(t2_ff[i]) >>> k_in;
         a_in[i] = a_sh[i][30:0];
         b_in[i] = b_sh[i][30:0];
      end

      rnd     = 35'(aprod2_ff) + 35'd32768;
      alpha_q = rnd[34:16];
      seg3_in = seg2_ff;
      seg3_in.alpha = (alpha_q > 19'(lsbe_pkg::ALPHA_ONE)) ? lsbe_pkg::ALPHA_ONE
                                                           : alpha_q[16:0];

      m_in[0] = a3_ff[1] * b3_ff[2];
      m_in[1] = a3_ff[2] * b3_ff[1];
      m_in[2] = a3_ff[2] * b3_ff[0];
      m_in[3] = a3_ff[0] * b3_ff[2];
      m_in[4] = a3_ff[0] * b3_ff[1];
      m_in[5] = a3_ff[1] * b3_ff[0];

      for (int i = 0; i < 3; i++) begin
         c_in[i] = m4_ff[2*i] - m4_ff[2*i+1];
      end

      // smallest r with every component >> r inside the int32 range
      for (int j = 0; j < 32; j++) begin
         fit_r[j] = 1'b1;
         for (int i = 0; i < 3; i++) begin
            if ((($unsigned(c5_ff[i]) ^ {63{c5_ff[i][62]}}) >> (31 + j)) != 63'd0)
               fit_r[j] = 1'b0;
         end
      end
      r_in = 6'd32;
      for (int j = 31; j >= 0; j--) begin
         if (fit_r[j]) r_in = 6'(j);
      end
      for (int i = 0; i < 3; i++) begin
         c_sh[i]  = c5_ff[i] >>> r_in;
         c2_in[i] = c_sh[i][31:0];
      end

      for (int i = 0; i < 3; i++) begin
         sq_in[i] = $signed(c2_6_ff[i]) * $signed(c2_6_ff[i]);
      end
      sum_in = sq7_ff[0] + sq7_ff[1] + sq7_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         seg1_ff   <= seg1_in;
         fade1_ff  <= in_fade;
         seg2_ff   <= seg1_ff;
         aprod2_ff <= aprod_in;
         seg3_ff   <= seg3_in;
         knz3_ff   <= (k_in != 3'd0);
         seg4_ff   <= seg3_ff;
         knz4_ff   <= knz3_ff;
         seg5_ff   <= seg4_ff;
         knz5_ff   <= knz4_ff;
         seg6_ff   <= seg5_ff;
         c2_6_ff   <= c2_in;
         scale6_ff <= knz5_ff || (r_in != 6'd0);
         seg7_ff   <= seg6_ff;
         c2_7_ff   <= c2_6_ff;
         scale7_ff <= scale6_ff;
         seg8_ff   <= seg7_ff;
         c2_8_ff   <= c2_7_ff;
         scale8_ff <= scale7_ff;
         sum8_ff   <= sum_in;
         for (int i = 0; i < 3; i++) begin
            d2_ff[i]  <= $unsigned(d_in[i]);
            t2_ff[i]  <= $unsigned(t_in[i]);
            a3_ff[i]  <= a_in[i];
            b3_ff[i]  <= b_in[i];
            c5_ff[i]  <= c_in[i];
            sq7_ff[i] <= sq_in[i];
         end
         for (int i = 0; i < 6; i++) begin
            m4_ff[i] <= m_in[i];
         end
      end
   end

   assign job_valid  = vld_ff[7];
   assign job.seg    = seg8_ff;
   assign job.c2     = c2_8_ff;
   assign job.sum_sq = sum8_ff;
   // zero length never divides; scaled or long enough vectors are normalised
   assign job.norm   = (sum8_ff != 64'd0) && (scale8_ff || (sum8_ff > lsbe_pkg::LEN_THRESH_SQ));

endmodule
`default_nettype wire

FILE: design/lsbe_queue.sv
`default_nettype none
module lsbe_queue #(
   parameter int DEPTH = 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push_valid,
   output logic                  push_ready,
   input  lsbe_pkg::lsbe_job_type push_data,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output lsbe_pkg::lsbe_job_type pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   lsbe_pkg::lsbe_job_type mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CW'(1);
      if (do_pop && !do_push) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_in;
         if (do_pop)  rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_data;
   end

endmodule
`default_nettype wire

FILE: design/lsbe_back.sv
`default_nettype none
module lsbe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   job_valid,
   output logic                   job_ready,
   input  lsbe_pkg::lsbe_job_type  job,
   output logic                   quad_valid,
   input  logic                   quad_ready,
   output lsbe_pkg::lsbe_quad_type quad
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SQRT = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_HOLD = 5'b10000
   } state_type;

   state_type            state_ff, state_in;
   logic [5:0]           cnt_ff, cnt_in;

   lsbe_pkg::lsbe_seg_type seg_ff;
   logic signed [31:0]   c2_ff [3];

   // square root
   logic [63:0]          x_ff;
   logic [34:0]          rem_ff, rem_in, rem_sh, trial;
   logic [31:0]          root_ff, root_in;

   // dividers, one per axis
   logic [31:0]          mag [3];
   logic [32:0]          dr_sh [3];
   logic [32:0]          dr_ff [3];
   logic [32:0]          dr_in [3];
   logic [32:0]          q_ff [3];
   logic [32:0]          q_in [3];
   logic                 ge [3];
   logic signed [33:0]   wq_in [3];
   logic signed [33:0]   w_ff [3];

   // shared multiplier: width vector times segment width, two halves per axis
   logic [1:0]           axis;
   logic signed [33:0]   w_sel;
   logic signed [17:0]   mul_a;
   logic signed [31:0]   mul_b;
   logic signed [49:0]   p_in, p_ff;
   logic [2:0]           tag_ff;
   logic signed [49:0]   acc_ff;
   logic signed [65:0]   tot_in;
   logic signed [33:0]   hi_in, off_in;
   logic signed [33:0]   off_ff [3];

   assign job_ready  = (state_ff == ST_IDLE);
   assign quad_valid = (state_ff == ST_HOLD);

   always_comb begin
      rem_sh  = {rem_ff[32:0], x_ff[63:62]};
      trial   = {1'b0, root_ff, 2'b01};
      rem_in  = rem_sh;
      root_in = {root_ff[30:0], 1'b0};
      if (rem_sh >= trial) begin
         rem_in  = rem_sh - trial;
         root_in = {root_ff[30:0], 1'b1};
      end

      for (int i = 0; i < 3; i++) begin
         mag[i]   = c2_ff[i][31] ? 32'(-c2_ff[i]) : 32'(c2_ff[i]);
         dr_sh[i] = (cnt_ff == 6'd0) ? {1'b0, mag[i]} : {dr_ff[i][31:0], 1'b0};
         ge[i]    = (dr_sh[i] >= {1'b0, root_ff});
         dr_in[i] = ge[i] ? dr_sh[i] - {1'b0, root_ff} : dr_sh[i];
         q_in[i]  = {q_ff[i][31:0], ge[i]};
         wq_in[i] = c2_ff[i][31] ? -$signed({1'b0, q_in[i]}) : $signed({1'b0, q_in[i]});
      end

      axis = cnt_ff[2:1];
      case (axis)
         2'd1:    w_sel = w_ff[1];
         2'd2:    w_sel = w_ff[2];
         default: w_sel = w_ff[0];
      endcase
      mul_a  = cnt_ff[0] ? {w_sel[33], w_sel[33:17]} : $signed({1'b0, w_sel[16:0]});
      mul_b  = $signed({1'b0, seg_ff.seg_width});
      p_in   = mul_a * mul_b;
      tot_in = acc_ff + (p_ff <<< 17);
      hi_in  = 34'(tot_in >>> 32);
      off_in = (hi_in + 34'sd1) >>> 1;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff + 6'd1;
      unique case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (job_valid) state_in = job.norm ? ST_SQRT : ST_MUL;
         end
         ST_SQRT: begin
            if (cnt_ff == 6'd31) begin
               state_in = ST_DIV;
               cnt_in   = '0;
            end
         end
         ST_DIV: begin
            if (cnt_ff == 6'd32) begin
               state_in = ST_MUL;
               cnt_in   = '0;
            end
         end
         ST_MUL: begin
            if (cnt_ff == 6'd6) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (quad_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            seg_ff  <= job.seg;
            x_ff    <= job.sum_sq;
            rem_ff  <= '0;
            root_ff <= '0;
            for (int i = 0; i < 3; i++) begin
               c2_ff[i] <= $signed(job.c2[i]);
               // short vectors stay unnormalised: cross product in Q.32
               w_ff[i]  <= 34'($signed(job.c2[i]) >>> 1);
            end
         end
         ST_SQRT: begin
            x_ff    <= x_ff << 2;
            rem_ff  <= rem_in;
            root_ff <= root_in;
         end
         ST_DIV: begin
            for (int i = 0; i < 3; i++) begin
               dr_ff[i] <= dr_in[i];
               q_ff[i]  <= q_in[i];
               if (cnt_ff == 6'd32) w_ff[i] <= wq_in[i];
            end
         end
         ST_MUL: begin
            if (cnt_ff != 6'd6) begin
               p_ff   <= p_in;
               tag_ff <= cnt_ff[2:0];
            end
            if (cnt_ff != 6'd0) begin
               if (!tag_ff[0]) begin
                  acc_ff <= p_ff;
               end else begin
                  case (tag_ff[2:1])
                     2'd1:    off_ff[1] <= off_in;
                     2'd2:    off_ff[2] <= off_in;
                     default: off_ff[0] <= off_in;
                  endcase
               end
            end
         end
         ST_HOLD: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      quad.seg = seg_ff;
      for (int i = 0; i < 3; i++) begin
         quad.off[i] = $unsigned(off_ff[i]);
      end
   end

endmodule
`default_nettype wire

FILE: design/lsbe_emit.sv
`default_nettype none
module lsbe_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   quad_valid,
   output logic                   quad_ready,
   input  lsbe_pkg::lsbe_quad_type quad,
   input  logic [16:0]            core_red,
   input  logic [16:0]            core_green,
   input  logic [16:0]            core_blue,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [31:0]            rsp_vertex_x,
   output logic [31:0]            rsp_vertex_y,
   output logic [31:0]            rsp_vertex_z,
   output logic [16:0]            rsp_out_red,
   output logic [16:0]            rsp_out_green,
   output logic [16:0]            rsp_out_blue,
   output logic [16:0]            rsp_out_alpha,
   output logic                   rsp_tex_u,
   output logic                   rsp_tex_v,
   output logic                   rsp_last_vertex
);

   logic                   busy_ff;
   logic [2:0]             vcnt_ff;
   lsbe_pkg::lsbe_quad_type quad_ff;
   logic [1:0]             corner;
   logic signed [34:0]     base [3];
   logic signed [34:0]     sum [3];
   logic [31:0]            pos [3];
   logic                   last;

   assign quad_ready = !busy_ff;
   assign rsp_valid  = busy_ff;
   assign corner     = lsbe_pkg::corner_of(vcnt_ff);
   assign last       = (vcnt_ff == lsbe_pkg::LAST_VERTEX);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         base[i] = corner[1] ? 35'($signed(quad_ff.seg.end_pt[i]))
                             : 35'($signed(quad_ff.seg.start_pt[i]));
         sum[i]  = corner[0] ? base[i] + 35'($signed(quad_ff.off[i]))
                             : base[i] - 35'($signed(quad_ff.off[i]));
         if (sum[i] > 35'sd2147483647)       pos[i] = 32'h7FFF_FFFF;
         else if (sum[i] < -35'sd2147483648) pos[i] = 32'h8000_0000;
         else                                pos[i] = sum[i][31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vcnt_ff <= '0;
      end else if (!busy_ff) begin
         busy_ff <= quad_valid;
         vcnt_ff <= '0;
      end else if (rsp_ready) begin
         busy_ff <= !last;
         vcnt_ff <= vcnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (!busy_ff) quad_ff <= quad;
   end

   assign rsp_vertex_x    = pos[0];
   assign rsp_vertex_y    = pos[1];
   assign rsp_vertex_z    = pos[2];
   assign rsp_out_red     = core_red;
   assign rsp_out_green   = core_green;
   assign rsp_out_blue    = core_blue;
   assign rsp_out_alpha   = quad_ff.seg.alpha;
   assign rsp_tex_u       = corner[0];
   assign rsp_tex_v       = corner[1];
   assign rsp_last_vertex = last;

endmodule
`default_nettype wire

FILE: design/lsbe_checker.sv
`default_nettype none
`include "line_segment_billboard_expander_macros.svh"
module lsbe_checker (
   input wire        clock,
   input wire        reset,
   input wire        req_ready,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [31:0] rsp_vertex_x,
   input wire [16:0] rsp_out_alpha,
   input wire        rsp_tex_u,
   input wire        rsp_tex_v,
   input wire        rsp_last_vertex
);

   `LSBE_ASSERT_AFTER_RESET(a_reset_empty, clock, reset, !rsp_valid && req_ready)
   `LSBE_ASSERT_NEXT(a_quad_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_vertex, rsp_valid)
   `LSBE_ASSERT_NOW(a_last_corner, clock, reset, rsp_valid && rsp_last_vertex, !rsp_tex_u && rsp_tex_v)
   `LSBE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex_x) && $stable(rsp_out_alpha) && $stable(rsp_last_vertex))

endmodule

bind line_segment_billboard_expander lsbe_checker u_lsbe_checker (.*);
`default_nettype wire
